@@ sv/ft3d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_pkg: shared types, constants and helpers
// Widths, point and control structs, register codes and saturation.
// ----------------------------------------------------------------------------
package ft3d_pkg;

  localparam int COORD_W   = 32;                // internal coordinate width
  localparam int REG_W     = 32;                // port fields and registers
  localparam int IDX_W     = 3;                 // configuration index width
  localparam int HALF_W    = 16;                // packed sine/cosine half
  localparam int COEF_W    = HALF_W + 1;        // holds a negated -2.0
  localparam int FRAC_BITS = 14;                // Q1.14 coefficients
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int SAT_W     = COORD_W + 18;      // sum of two products, exact

  localparam logic signed [SAT_W-1:0] ROUND_HALF = SAT_W'(1) <<< (FRAC_BITS - 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [REG_W-1:0]   word_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SAT_W-1:0]   wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } port_pt_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [1:0] {
    OFS_PASS,
    OFS_SUB,
    OFS_ADD
  } ofs_op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DIRECTION,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_ALPHA,
    REG_BETA,
    REG_GAMMA
  } reg_idx_t;

  typedef enum logic {
    DIR_TO_LOCAL,
    DIR_FROM_LOCAL
  } dir_t;

  typedef struct packed {
    dir_t             direction;
    port_pt_t         origin;
    logic [REG_W-1:0] alpha;
    logic [REG_W-1:0] beta;
    logic [REG_W-1:0] gamma;
  } cfg_t;

  typedef struct packed {
    axis_t axis;
    coef_t s;
    coef_t c;
  } rot_ctl_t;

  // clamp a signed value to the range of a w-bit signed number
  function automatic wide_t sat_to(input wide_t v, input int w);
    wide_t mx;
    wide_t mn;
    mx = (SAT_W'(1) <<< (w - 1)) - SAT_W'(1);
    mn = ~mx;
    if (v > mx) return mx;
    if (v < mn) return mn;
    return v;
  endfunction

  // Q1.14 half to coefficient, optionally negated (exact in COEF_W bits)
  function automatic coef_t coef_of(input logic [HALF_W-1:0] h, input logic neg);
    coef_t k;
    k = COEF_W'($signed(h));
    return neg ? -k : k;
  endfunction

endpackage : ft3d_pkg
`default_nettype wire

@@ sv/ft3d_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_in_if: point input channel
// Valid/ready channel carrying one point per request.
// ----------------------------------------------------------------------------
interface ft3d_in_if import ft3d_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t in_x;
  word_t in_y;
  word_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface : ft3d_in_if
`default_nettype wire

@@ sv/ft3d_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_out_if: point result channel
// Valid/ready channel carrying one transformed point per request.
// ----------------------------------------------------------------------------
interface ft3d_out_if import ft3d_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t out_x;
  word_t out_y;
  word_t out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface : ft3d_out_if
`default_nettype wire

@@ sv/ft3d_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ft3d_cfg_if import ft3d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : ft3d_cfg_if
`default_nettype wire

@@ sv/ft3d_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_cfg_regs: configuration register file
// Direction, origin and packed sine/cosine registers; unknown indexes ignored.
// ----------------------------------------------------------------------------
module ft3d_cfg_regs import ft3d_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  ft3d_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DIRECTION: cfg_nxt.direction = dir_t'(cfg_ch.data[0]);
        REG_ORIGIN_X:  cfg_nxt.origin.x  = $signed(cfg_ch.data);
        REG_ORIGIN_Y:  cfg_nxt.origin.y  = $signed(cfg_ch.data);
        REG_ORIGIN_Z:  cfg_nxt.origin.z  = $signed(cfg_ch.data);
        REG_ALPHA:     cfg_nxt.alpha     = cfg_ch.data;
        REG_BETA:      cfg_nxt.beta      = cfg_ch.data;
        REG_GAMMA:     cfg_nxt.gamma     = cfg_ch.data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction <= DIR_TO_LOCAL;
      cfg_r.origin    <= '0;
      // identity rotation: sine 0, cosine 1.0
      cfg_r.alpha     <= REG_W'(1) << FRAC_BITS;
      cfg_r.beta      <= REG_W'(1) << FRAC_BITS;
      cfg_r.gamma     <= REG_W'(1) << FRAC_BITS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule : ft3d_cfg_regs
`default_nettype wire

@@ sv/ft3d_ofs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_ofs: origin offset stage
// Subtracts, adds or passes the frame origin, saturating to the coordinate range.
// ----------------------------------------------------------------------------
module ft3d_ofs import ft3d_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           en,
  input  wire           valid_in,
  input  wire point_t   pt_in,
  input  wire ofs_op_t  op,
  input  wire port_pt_t origin,
  output logic          valid_out,
  output point_t        pt_out
);

  logic   valid_r;
  point_t pt_r;
  point_t pt_nxt;

  function automatic coord_t offs(input coord_t p, input word_t o, input ofs_op_t k);
    wide_t s;
    wide_t t;
    unique case (k)
      OFS_SUB: s = SAT_W'(p) - SAT_W'(o);
      OFS_ADD: s = SAT_W'(p) + SAT_W'(o);
      default: s = SAT_W'(p);
    endcase
    t = sat_to(s, COORD_W);
    return t[COORD_W-1:0];
  endfunction

  always_comb begin
    pt_nxt.x = offs(pt_in.x, origin.x, op);
    pt_nxt.y = offs(pt_in.y, origin.y, op);
    pt_nxt.z = offs(pt_in.z, origin.z, op);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r <= pt_nxt;
    end
  end

  assign valid_out = valid_r;
  assign pt_out    = pt_r;

endmodule : ft3d_ofs
`default_nettype wire

@@ sv/ft3d_rot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_rot: single-axis rotation unit
// Two stages: four coordinate-by-coefficient products, then the two rounded,
// saturated sums written back into the selected coordinate pair.
// ----------------------------------------------------------------------------
module ft3d_rot import ft3d_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           en,
  input  wire           valid_in,
  input  wire point_t   pt_in,
  input  wire rot_ctl_t ctl,
  output logic          valid_out,
  output point_t        pt_out
);

  // pair (a, b): X -> (y, z), Y -> (z, x), Z -> (x, y)
  // a' = a*c - b*s, b' = a*s + b*c
  coord_t a;
  coord_t b;

  logic   v1_r;
  point_t pt1_r;
  axis_t  axis1_r;
  prod_t  pac_r, pbs_r, pas_r, pbc_r;

  logic   v2_r;
  point_t pt2_r;
  point_t pt2_nxt;

  wide_t  na_sum, nb_sum, na_sh, nb_sh, na_sat, nb_sat;
  coord_t na, nb;

  always_comb begin
    unique case (ctl.axis)
      AXIS_X:  begin a = pt_in.y; b = pt_in.z; end
      AXIS_Y:  begin a = pt_in.z; b = pt_in.x; end
      AXIS_Z:  begin a = pt_in.x; b = pt_in.y; end
      default: begin a = pt_in.y; b = pt_in.z; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1_r   <= pt_in;
      axis1_r <= ctl.axis;
      pac_r   <= PROD_W'(a) * PROD_W'(ctl.c);
      pbs_r   <= PROD_W'(b) * PROD_W'(ctl.s);
      pas_r   <= PROD_W'(a) * PROD_W'(ctl.s);
      pbc_r   <= PROD_W'(b) * PROD_W'(ctl.c);
    end
  end

  always_comb begin
    na_sum = SAT_W'(pac_r) - SAT_W'(pbs_r) + ROUND_HALF;
    nb_sum = SAT_W'(pas_r) + SAT_W'(pbc_r) + ROUND_HALF;
    na_sh  = na_sum >>> FRAC_BITS;
    nb_sh  = nb_sum >>> FRAC_BITS;
    na_sat = sat_to(na_sh, COORD_W);
    nb_sat = sat_to(nb_sh, COORD_W);
    na     = na_sat[COORD_W-1:0];
    nb     = nb_sat[COORD_W-1:0];

    pt2_nxt = pt1_r;
    unique case (axis1_r)
      AXIS_X:  begin pt2_nxt.y = na; pt2_nxt.z = nb; end
      AXIS_Y:  begin pt2_nxt.z = na; pt2_nxt.x = nb; end
      AXIS_Z:  begin pt2_nxt.x = na; pt2_nxt.y = nb; end
      default: begin pt2_nxt.y = na; pt2_nxt.z = nb; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt2_r <= pt2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_in;
      v2_r <= v1_r;
    end
  end

  assign valid_out = v2_r;
  assign pt_out    = pt2_r;

endmodule : ft3d_rot
`default_nettype wire

@@ sv/ft3d_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft3d_out_buf: output register with skid entry
// Holds results against a stalled sink; the pipeline advances while the
// skid entry is empty.
// ----------------------------------------------------------------------------
module ft3d_out_buf import ft3d_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           last_valid,
  input  wire port_pt_t last_pt,
  output logic          advance,
  ft3d_out_if.source    out_ch
);

  logic     out_valid_r, out_valid_nxt;
  port_pt_t out_pt_r, out_pt_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  port_pt_t skid_pt_r, skid_pt_nxt;
  logic     push;

  assign advance = !skid_valid_r;
  assign push    = last_valid && !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_pt_nxt     = out_pt_r;
    skid_valid_nxt = skid_valid_r;
    skid_pt_nxt    = skid_pt_r;
    if (out_valid_r && !out_ch.ready) begin
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_pt_nxt    = last_pt;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_pt_nxt     = skid_pt_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = push;
      out_pt_nxt    = last_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pt_r  <= out_pt_nxt;
    skid_pt_r <= skid_pt_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_x = out_pt_r.x;
  assign out_ch.out_y = out_pt_r.y;
  assign out_ch.out_z = out_pt_r.z;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed while skid entry full");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && push) |=> skid_valid_r)
    else $error("result lost on a stalled output");
`endif

endmodule : ft3d_out_buf
`default_nettype wire

@@ sv/frame_transform_3d_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_transform_3d_top: 3D rigid frame transform (X-Y-Z Euler rotations)
// Q16.16 points, Q1.14 sine/cosine pairs, saturating arithmetic.
// ----------------------------------------------------------------------------
// One point enters per clock while in_ch.ready is high; its result passes the
// origin stage, three rotation units of two stages each, the origin stage and
// the output register. Each rotation unit multiplies in one stage and sums,
// rounds and saturates in the next. in_ch.ready is low only while the
// output skid entry holds a result, i.e. after the sink has stalled; the whole
// pipeline then holds. Write configuration only when no point is in flight.
// ----------------------------------------------------------------------------
module frame_transform_3d_top import ft3d_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  ft3d_in_if.sink    in_ch,
  ft3d_out_if.source out_ch,
  ft3d_cfg_if.sink   cfg_ch
);

  cfg_t     cfg;
  logic     en;
  logic     from_local;
  point_t   in_pt;
  ofs_op_t  front_op, back_op;
  rot_ctl_t ctl1, ctl2, ctl3;

  logic     v_f, v_r1, v_r2, v_r3, v_b;
  point_t   pt_f, pt_r1, pt_r2, pt_r3, pt_b;
  port_pt_t last_pt;

  function automatic coord_t sat_in(input word_t v);
    wide_t t;
    t = sat_to(SAT_W'(v), COORD_W);
    return t[COORD_W-1:0];
  endfunction

  function automatic word_t sat_out(input coord_t v);
    wide_t t;
    t = sat_to(SAT_W'(v), REG_W);
    return t[REG_W-1:0];
  endfunction

  ft3d_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign from_local = (cfg.direction == DIR_FROM_LOCAL);
  assign front_op   = from_local ? OFS_PASS : OFS_SUB;
  assign back_op    = from_local ? OFS_ADD  : OFS_PASS;

  // to local: X, Y, Z; from local: Z, Y, X with negated sines
  always_comb begin
    ctl1.axis = from_local ? AXIS_Z : AXIS_X;
    ctl1.s    = from_local ? coef_of(cfg.gamma[REG_W-1:HALF_W], 1'b1)
                           : coef_of(cfg.alpha[REG_W-1:HALF_W], 1'b0);
    ctl1.c    = from_local ? coef_of(cfg.gamma[HALF_W-1:0], 1'b0)
                           : coef_of(cfg.alpha[HALF_W-1:0], 1'b0);
    ctl2.axis = AXIS_Y;
    ctl2.s    = coef_of(cfg.beta[REG_W-1:HALF_W], from_local);
    ctl2.c    = coef_of(cfg.beta[HALF_W-1:0], 1'b0);
    ctl3.axis = from_local ? AXIS_X : AXIS_Z;
    ctl3.s    = from_local ? coef_of(cfg.alpha[REG_W-1:HALF_W], 1'b1)
                           : coef_of(cfg.gamma[REG_W-1:HALF_W], 1'b0);
    ctl3.c    = from_local ? coef_of(cfg.alpha[HALF_W-1:0], 1'b0)
                           : coef_of(cfg.gamma[HALF_W-1:0], 1'b0);
  end

  assign in_ch.ready = en;

  always_comb begin
    in_pt.x = sat_in(in_ch.in_x);
    in_pt.y = sat_in(in_ch.in_y);
    in_pt.z = sat_in(in_ch.in_z);
  end

  ft3d_ofs u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (in_ch.valid),
    .pt_in     (in_pt),
    .op        (front_op),
    .origin    (cfg.origin),
    .valid_out (v_f),
    .pt_out    (pt_f)
  );

  ft3d_rot u_rot1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v_f),
    .pt_in     (pt_f),
    .ctl       (ctl1),
    .valid_out (v_r1),
    .pt_out    (pt_r1)
  );

  ft3d_rot u_rot2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v_r1),
    .pt_in     (pt_r1),
    .ctl       (ctl2),
    .valid_out (v_r2),
    .pt_out    (pt_r2)
  );

  ft3d_rot u_rot3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v_r2),
    .pt_in     (pt_r2),
    .ctl       (ctl3),
    .valid_out (v_r3),
    .pt_out    (pt_r3)
  );

  ft3d_ofs u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v_r3),
    .pt_in     (pt_r3),
    .op        (back_op),
    .origin    (cfg.origin),
    .valid_out (v_b),
    .pt_out    (pt_b)
  );

  always_comb begin
    last_pt.x = sat_out(pt_b.x);
    last_pt.y = sat_out(pt_b.y);
    last_pt.z = sat_out(pt_b.z);
  end

  ft3d_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_valid (v_b),
    .last_pt    (last_pt),
    .advance    (en),
    .out_ch     (out_ch)
  );

endmodule : frame_transform_3d_top
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: point stream check for frame_transform_3d_top
// Streams points through the block under a series of register settings.
// Every accepted point is mapped by an independent fixed-point predictor,
// and each result is compared field by field, in order, with what is due.
// Sender gaps and receiver stalls are randomized in three idling modes.
// ----------------------------------------------------------------------------
module testbench;
  import ft3d_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_DEPTH  = 9;      // register stages, input to output
  localparam int SETTINGS_PER_MODE = 6;
  localparam int POINTS_PER_SETTING = 70;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;   // no register behind it
  localparam word_t MAX_WORD = 32'sh7FFF_FFFF;
  localparam word_t MIN_WORD = 32'sh8000_0000;

  // predictor plus the in-order list of results still due
  class point_tracker;
    localparam logic [REG_W-1:0] UNIT_PAIR = 32'h0000_4000;  // sin 0, cos 1.0

    dir_t             dir;
    word_t            org_x, org_y, org_z;
    logic [REG_W-1:0] rot_a, rot_b, rot_g;
    port_pt_t         due_points[$];
    int               errors;
    int               checked;

    function new();
      dir = DIR_TO_LOCAL;
      org_x = 0;
      org_y = 0;
      org_z = 0;
      rot_a = UNIT_PAIR;
      rot_b = UNIT_PAIR;
      rot_g = UNIT_PAIR;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] d);
      case (idx)
        REG_DIRECTION: dir = dir_t'(d[0]);
        REG_ORIGIN_X:  org_x = d;
        REG_ORIGIN_Y:  org_y = d;
        REG_ORIGIN_Z:  org_z = d;
        REG_ALPHA:     rot_a = d;
        REG_BETA:      rot_b = d;
        REG_GAMMA:     rot_g = d;
        default: ;
      endcase
    endfunction

    function int clamp(longint v);
      if (v > 64'sd2147483647) return MAX_WORD;
      if (v < -64'sd2147483648) return MIN_WORD;
      return int'(v);
    endfunction

    // (a*c1 + b*c2) / 2^14, round half up
    function int blend(int a, int c1, int b, int c2);
      longint acc;
      acc = longint'(a) * longint'(c1) + longint'(b) * longint'(c2) + 64'sd8192;
      return clamp(acc >>> FRAC_BITS);
    endfunction

    // planar rotation of (u, v); the Y axis uses it as (z, x)
    function void turn(inout int u, inout int v, input int s, input int c);
      int nu;
      nu = blend(u, c, v, -s);
      v = blend(u, s, v, c);
      u = nu;
    endfunction

    function int sine_of(logic [REG_W-1:0] w, bit neg);
      int k;
      k = int'($signed(w[31:16]));
      return neg ? -k : k;
    endfunction

    function int cosine_of(logic [REG_W-1:0] w);
      return int'($signed(w[15:0]));
    endfunction

    function port_pt_t map_point(port_pt_t p);
      int x, y, z;
      bit back;
      port_pt_t r;
      back = (dir == DIR_FROM_LOCAL);
      x = p.x;
      y = p.y;
      z = p.z;
      if (!back) begin
        x = clamp(longint'(x) - longint'(org_x));
        y = clamp(longint'(y) - longint'(org_y));
        z = clamp(longint'(z) - longint'(org_z));
        turn(y, z, sine_of(rot_a, 0), cosine_of(rot_a));
        turn(z, x, sine_of(rot_b, 0), cosine_of(rot_b));
        turn(x, y, sine_of(rot_g, 0), cosine_of(rot_g));
      end else begin
        turn(x, y, sine_of(rot_g, 1), cosine_of(rot_g));
        turn(z, x, sine_of(rot_b, 1), cosine_of(rot_b));
        turn(y, z, sine_of(rot_a, 1), cosine_of(rot_a));
        x = clamp(longint'(x) + longint'(org_x));
        y = clamp(longint'(y) + longint'(org_y));
        z = clamp(longint'(z) + longint'(org_z));
      end
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
    endfunction

    function void note_point(port_pt_t p);
      due_points.push_back(map_point(p));
    endfunction

    function int pending();
      return due_points.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_field(string name, word_t got, word_t want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, want %h", checked, name, got, want));
    endtask

    task check_point(port_pt_t got);
      port_pt_t want;
      if (due_points.size() == 0) begin
        report($sformatf("result %h with nothing due", got));
      end else begin
        want = due_points.pop_front();
        checked++;
        check_field("x", got.x, want.x);
        check_field("y", got.y, want.y);
        check_field("z", got.z, want.z);
      end
    endtask

    task close();
      if (due_points.size() != 0)
        report($sformatf("%0d results never arrived", due_points.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycles = 0;
  int   n_settings = 0;
  point_tracker tracker;

  ft3d_in_if  in_ch();
  ft3d_out_if out_ch();
  ft3d_cfg_if cfg_ch();

  frame_transform_3d_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_point(port_pt_t'({out_ch.out_x, out_ch.out_y, out_ch.out_z}));
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_point(input port_pt_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x  <= p.x;
    in_ch.in_y  <= p.y;
    in_ch.in_z  <= p.z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_point(p);
    @(negedge clk);
  endtask

  // valid is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic apply_setting(input cfg_t s);
    write_reg(REG_DIRECTION, {{(REG_W-1){1'b0}}, s.direction});
    write_reg(REG_ORIGIN_X, s.origin.x);
    write_reg(REG_ORIGIN_Y, s.origin.y);
    write_reg(REG_ORIGIN_Z, s.origin.z);
    write_reg(REG_ALPHA, s.alpha);
    write_reg(REG_BETA, s.beta);
    write_reg(REG_GAMMA, s.gamma);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  function automatic cfg_t make_setting(dir_t d, word_t ox, word_t oy, word_t oz,
                                        logic [REG_W-1:0] a, logic [REG_W-1:0] b,
                                        logic [REG_W-1:0] g);
    cfg_t s;
    s.direction = d;
    s.origin.x = ox;
    s.origin.y = oy;
    s.origin.z = oz;
    s.alpha = a;
    s.beta = b;
    s.gamma = g;
    return s;
  endfunction

  function automatic word_t rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return word_t'(int'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
      2: begin
        case ($urandom_range(4))
          0: return MAX_WORD;
          1: return MIN_WORD;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return word_t'(int'($urandom) >>> $urandom_range(8, 20));
    endcase
  endfunction

  function automatic logic [15:0] extreme_half();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_angle();
    int s;
    int c;
    case ($urandom_range(5))
      0: return $urandom;
      1: return {extreme_half(), extreme_half()};
      default: begin
        // roughly unit-length pair, as a real angle would give
        s = int'($urandom_range(0, 32768)) - 16384;
        c = $rtoi($sqrt(268435456.0 - real'(s * s)) + 0.5);
        if ($urandom_range(1) == 1) c = -c;
        return {s[15:0], c[15:0]};
      end
    endcase
  endfunction

  function automatic port_pt_t rand_point();
    port_pt_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    return p;
  endfunction

  function automatic cfg_t rand_setting();
    return make_setting(dir_t'($urandom_range(1)), rand_coord(), rand_coord(),
                        rand_coord(), rand_angle(), rand_angle(), rand_angle());
  endfunction

  initial begin : stimulus
    port_pt_t probes[5];
    int mode;
    int k;
    int n;
    tracker = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_idle_pct = 24;
    recv_stall_pct = 49;

    probes[0] = {32'sh0, 32'sh0, 32'sh0};
    probes[1] = {MAX_WORD, MIN_WORD, -32'sh1};
    probes[2] = {MIN_WORD, MAX_WORD, 32'sh1};
    probes[3] = {MIN_WORD, MIN_WORD, MAX_WORD};
    probes[4] = {32'sh0001_2345, -32'sh0000_ABCD, 32'sh0000_2001};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // identity transform straight out of reset
    foreach (probes[i]) send_point(probes[i]);
    settle();
    // inverse with sine -2.0 (negates to +2.0) and origins at the rails
    apply_setting(make_setting(DIR_FROM_LOCAL, MAX_WORD, MIN_WORD, 32'sh0001_8000,
                               32'h8000_8000, 32'h7FFF_7FFF, 32'h0000_C000));
    foreach (probes[i]) send_point(probes[i]);
    settle();
    // origin subtract overflows, non-unit pairs
    apply_setting(make_setting(DIR_TO_LOCAL, MIN_WORD, MAX_WORD, -32'sh1,
                               32'hFFFF_FFFF, 32'h8000_0000, 32'h2D41_2D41));
    foreach (probes[i]) send_point(probes[i]);
    settle();
    apply_setting(make_setting(DIR_FROM_LOCAL, 32'sh0A00_0000, -32'sh0A00_0000,
                               32'sh1, 32'h2D41_2D41, 32'h0000_0000, 32'hFFFF_8000));
    foreach (probes[i]) send_point(probes[i]);
    settle();
    // write past the register list must change nothing
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_ch.valid <= 1'b0;
    send_point(probes[4]);
    send_point(probes[1]);

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 24;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (k = 0; k < SETTINGS_PER_MODE; k++) begin
        settle();
        apply_setting(rand_setting());
        repeat (POINTS_PER_SETTING) send_point(rand_point());
      end
    end

    in_ch.valid <= 1'b0;
    n = 0;
    while (tracker.pending() != 0 && n < 2000) begin
      @(negedge clk);
      n++;
    end
    repeat (PIPE_DEPTH + 4) @(negedge clk);
    tracker.close();

    $display("covered %0d points under %0d register settings in both directions,",
             tracker.checked, n_settings);
    $display("with rail values, unnormalized sine/cosine pairs and stalls on both sides");
    if (tracker.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
